### src/tlfs_pkg.sv
// tlfs_pkg: types, constants and codes of the two-level feedback scheduler
// used by tlfs_ctrl, tlfs_dp and two_level_feedback_scheduler; no dependencies
package tlfs_pkg;

    localparam int NPROC  = 16;
    localparam int SLOT_W = $clog2(NPROC);
    localparam int CNT_W  = SLOT_W + 1;

    // input modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_QUANTUM = 2'd0;
    localparam logic [1:0] CFG_SLICE   = 2'd1;
    localparam logic [1:0] CFG_PCOUNT  = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [3:0]  slot;
        logic [15:0] process_id;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  priority_req;
    } t_in_item;

    typedef struct packed {
        logic        ran_valid;
        logic [3:0]  ran_slot;
        logic [15:0] ran_process_id;
        logic        from_round_robin;
        logic        finished;
        logic [31:0] response_time;
        logic [31:0] finish_time;
        logic [31:0] waiting_time;
        logic        all_done;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_SEL,
        ST_RR_FETCH,
        ST_RR_EXEC,
        ST_L1_FETCH,
        ST_L1_ROT,
        ST_L1_START,
        ST_L1_DEMOTE,
        ST_L1_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_state op;
        logic   accept;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic rr_path;
        logic rot_path;
        logic out_free;
    } t_status;

endpackage

### src/two_level_feedback_scheduler.sv
// Two-level feedback scheduler. A load item writes one of 16 process slots in a
// single load state. A tick item scans the slots in use one slot per cycle, at least
// one slot even when none is in use, and then makes a short sequence of single-slot
// updates: a select step, then start, demote and run on the level-one path, with a
// fetch and a rotate first when a partly used round-robin head is moved to the back,
// or a fetch and an execute step for a round-robin turn. One result per tick waits
// in an output register, so the next item is taken while it is still pending; a tick
// whose result register is still full stalls in its last state until that result is
// taken. Configuration writes are accepted in every cycle and must come only while idle.
// top level: joins tlfs_ctrl and tlfs_dp; depends on tlfs_pkg
module two_level_feedback_scheduler (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tlfs_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tlfs_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data
);
    import tlfs_pkg::*;

    t_cmd    cmd;
    t_status status;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    tlfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_in_data.mode),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    tlfs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

### src/tlfs_ctrl.sv
// tlfs_ctrl: sequencer for load and tick items of the scheduler
// depends on tlfs_pkg
module tlfs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_mode,
    input  tlfs_pkg::t_status i_status,
    output tlfs_pkg::t_cmd   o_cmd,
    output logic             o_in_ready
);
    import tlfs_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_mode == MODE_LOAD) ? ST_LOAD : ST_SCAN;
                end
            end
            ST_LOAD:      n_state = ST_IDLE;
            ST_SCAN: begin
                if (i_status.scan_last) n_state = ST_SEL;
            end
            ST_SEL: begin
                if (i_status.rr_path)       n_state = ST_RR_FETCH;
                else if (i_status.rot_path) n_state = ST_L1_FETCH;
                else                        n_state = ST_L1_START;
            end
            ST_RR_FETCH:  n_state = ST_RR_EXEC;
            ST_RR_EXEC:   n_state = ST_DONE;
            ST_L1_FETCH:  n_state = ST_L1_ROT;
            ST_L1_ROT:    n_state = ST_L1_START;
            ST_L1_START:  n_state = ST_L1_DEMOTE;
            ST_L1_DEMOTE: n_state = ST_L1_RUN;
            ST_L1_RUN:    n_state = ST_DONE;
            ST_DONE: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd.op     = r_state;
        o_in_ready   = (r_state == ST_IDLE);
        o_cmd.accept = (r_state == ST_IDLE) && i_in_valid;
    end

endmodule

### src/tlfs_dp.sv
// tlfs_dp: process table, round-robin queue, scan and result registers
// depends on tlfs_pkg; driven by tlfs_ctrl commands
module tlfs_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tlfs_pkg::t_cmd     i_cmd,
    input  tlfs_pkg::t_in_item i_in_data,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_out_ready,
    output tlfs_pkg::t_status  o_status,
    output logic               o_out_valid,
    output tlfs_pkg::t_out_item o_out_data
);
    import tlfs_pkg::*;

    // configuration
    logic [7:0]       r_quantum, r_slice;
    logic [CNT_W-1:0] r_pcount;

    // process table
    logic [15:0]       r_arr   [NPROC];
    logic [15:0]       r_burst [NPROC];
    logic [15:0]       r_rem   [NPROC];
    logic [7:0]        r_pri   [NPROC];
    logic [15:0]       r_id    [NPROC];
    logic [31:0]       r_resp  [NPROC];
    logic [7:0]        r_su    [NPROC];
    logic [SLOT_W-1:0] r_q     [NPROC];
    logic [NPROC-1:0]  r_dem, r_start, r_nz;

    // scheduler state
    logic [31:0]       r_tick;
    logic [SLOT_W-1:0] r_head;
    logic [CNT_W-1:0]  r_cnt;
    logic [SLOT_W-1:0] r_prev;
    logic              r_prev_valid;

    // per-tick working registers
    t_in_item          r_item;
    logic [CNT_W-1:0]  r_idx;
    logic              r_found;
    logic [SLOT_W-1:0] r_best;
    logic [8:0]        r_bestp;
    logic [SLOT_W-1:0] r_f;
    t_out_item         r_res;
    t_out_item         r_out;
    logic              r_out_valid;

    logic [CNT_W-1:0]  n_lim;
    logic [SLOT_W-1:0] addr;
    logic [15:0]       rd_rem, rem_dec, ran;
    logic [7:0]        rd_su, su_inc;
    logic [31:0]       ft, wt;
    logic              cand, out_free, all_done;
    logic [NPROC-1:0]  mask;

    // actions
    logic              q_wr, head_inc, cnt_inc, cnt_dec;
    logic [SLOT_W-1:0] q_wr_data;
    logic              su_wr, rem_wr, dem_set, start_set, run, fin, rr_unit;
    logic [7:0]        su_val;
    logic [SLOT_W-1:0] push_slot;
    logic              do_push;

    assign n_lim = (r_pcount > CNT_W'(NPROC)) ? CNT_W'(NPROC) : r_pcount;

    // table address for the current step
    always_comb begin
        case (i_cmd.op)
            ST_SCAN:      addr = r_idx[SLOT_W-1:0];
            ST_RR_EXEC:   addr = r_f;
            ST_L1_ROT:    addr = r_f;
            ST_L1_DEMOTE: addr = r_prev;
            default:      addr = r_best;
        endcase
    end

    assign rd_rem  = r_rem[addr];
    assign rd_su   = r_su[addr];
    assign rem_dec = rd_rem - 16'd1;
    assign su_inc  = rd_su + 8'd1;
    assign ran     = r_burst[addr] - rem_dec;
    assign ft      = (&r_tick) ? r_tick : r_tick + 32'd1;
    assign wt      = ft - {16'd0, r_burst[addr]} - {16'd0, r_arr[addr]};

    // scan candidate
    assign cand = (r_idx < n_lim) && ({16'd0, r_arr[addr]} <= r_tick)
                  && ({1'b0, r_pri[addr]} < r_bestp) && r_nz[addr] && !r_dem[addr];

    // slots in use and completion
    always_comb begin
        for (int i = 0; i < NPROC; i++) begin
            mask[i] = (CNT_W'(i) < n_lim);
        end
    end
    assign all_done = ~|(r_nz & mask);

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_status.scan_last = ({1'b0, r_idx} + (CNT_W+1)'(1)) >= {1'b0, n_lim};
        o_status.rr_path   = !r_found && (r_cnt != '0);
        o_status.rot_path  = r_found && (r_cnt != '0) && !r_prev_valid;
        o_status.out_free  = out_free;
    end

    // step decisions
    always_comb begin
        q_wr      = 1'b0;
        q_wr_data = r_f;
        head_inc  = 1'b0;
        cnt_inc   = 1'b0;
        cnt_dec   = 1'b0;
        su_wr     = 1'b0;
        su_val    = 8'd0;
        rem_wr    = 1'b0;
        dem_set   = 1'b0;
        start_set = 1'b0;
        run       = 1'b0;
        fin       = 1'b0;
        rr_unit   = 1'b0;
        do_push   = 1'b0;
        push_slot = addr;
        case (i_cmd.op)
            ST_RR_EXEC: begin
                if (!r_nz[addr]) begin
                    head_inc = 1'b1;
                    cnt_dec  = 1'b1;
                end else if (rd_su >= r_slice) begin
                    su_wr    = 1'b1;
                    q_wr     = 1'b1;
                    head_inc = 1'b1;
                end else begin
                    su_wr   = 1'b1;
                    su_val  = su_inc;
                    rem_wr  = 1'b1;
                    run     = 1'b1;
                    rr_unit = 1'b1;
                    if (rem_dec == 16'd0) begin
                        fin      = 1'b1;
                        head_inc = 1'b1;
                        cnt_dec  = 1'b1;
                    end else if (su_inc == r_slice) begin
                        su_val   = 8'd0;
                        q_wr     = 1'b1;
                        head_inc = 1'b1;
                    end
                end
            end
            ST_L1_ROT: begin
                if (rd_su >= 8'd1 && rd_su <= r_slice) begin
                    q_wr     = 1'b1;
                    head_inc = 1'b1;
                end
            end
            ST_L1_START: begin
                start_set = r_found && !r_start[addr];
            end
            ST_L1_DEMOTE: begin
                if (r_prev_valid && (!r_found || r_best != r_prev) && !r_dem[addr]) begin
                    do_push = 1'b1;
                    dem_set = 1'b1;
                end
            end
            ST_L1_RUN: begin
                if (r_found) begin
                    rem_wr = 1'b1;
                    run    = 1'b1;
                    if (rem_dec == 16'd0) begin
                        dem_set = 1'b1;
                        fin     = 1'b1;
                    end else if (ran == {8'd0, r_quantum}) begin
                        dem_set = 1'b1;
                        do_push = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        // push into the tail when there is room
        if (do_push && (r_cnt < CNT_W'(NPROC))) begin
            q_wr      = 1'b1;
            q_wr_data = push_slot;
            cnt_inc   = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum    <= 8'd4;
            r_slice      <= 8'd4;
            r_pcount     <= '0;
            r_tick       <= '0;
            r_head       <= '0;
            r_cnt        <= '0;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
            r_dem        <= '0;
            r_start      <= '0;
            r_nz         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // configuration transfer
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_QUANTUM: r_quantum <= i_cfg_data;
                    CFG_SLICE:   r_slice   <= i_cfg_data;
                    CFG_PCOUNT:  r_pcount  <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            // load clears the demoted and started flags and sets the nonzero flag from the burst
            if (i_cmd.op == ST_LOAD) begin
                r_dem[r_item.slot]   <= 1'b0;
                r_start[r_item.slot] <= 1'b0;
                r_nz[r_item.slot]    <= |r_item.burst;
            end
            if (i_cmd.op == ST_SEL && o_status.rr_path) r_prev_valid <= 1'b0;
            if (i_cmd.op == ST_L1_RUN) begin
                r_prev_valid <= r_found;
                r_prev       <= r_best;
            end
            if (dem_set)   r_dem[addr]   <= 1'b1;
            if (start_set) r_start[addr] <= 1'b1;
            if (rem_wr)    r_nz[addr]    <= |rem_dec;
            // queue pointers
            if (head_inc) r_head <= r_head + SLOT_W'(1);
            if (cnt_inc)      r_cnt <= r_cnt + CNT_W'(1);
            else if (cnt_dec) r_cnt <= r_cnt - CNT_W'(1);
            // result register
            if (i_cmd.op == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
                if (!(&r_tick)) r_tick <= r_tick + 32'd1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // tables and working payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item  <= i_in_data;
            r_idx   <= '0;
            r_found <= 1'b0;
            r_best  <= '0;
            r_bestp <= 9'h100;
            r_res   <= '0;
        end
        if (i_cmd.op == ST_LOAD) begin
            r_id[r_item.slot]    <= r_item.process_id;
            r_arr[r_item.slot]   <= r_item.arrival;
            r_burst[r_item.slot] <= r_item.burst;
            r_rem[r_item.slot]   <= r_item.burst;
            r_pri[r_item.slot]   <= r_item.priority_req;
            r_su[r_item.slot]    <= 8'd0;
        end
        // one slot per cycle of the scan
        if (i_cmd.op == ST_SCAN) begin
            r_idx <= r_idx + CNT_W'(1);
            if (cand) begin
                r_found <= 1'b1;
                r_best  <= addr;
                r_bestp <= {1'b0, r_pri[addr]};
            end
        end
        if (i_cmd.op == ST_RR_FETCH || i_cmd.op == ST_L1_FETCH) begin
            r_f <= r_q[r_head];
        end
        if (q_wr)      r_q[r_head + r_cnt[SLOT_W-1:0]] <= q_wr_data;
        if (su_wr)     r_su[addr]   <= su_val;
        if (rem_wr)    r_rem[addr]  <= rem_dec;
        if (start_set) r_resp[addr] <= r_tick - {16'd0, r_arr[addr]};
        if (run) begin
            r_res.ran_valid        <= 1'b1;
            r_res.ran_slot         <= addr;
            r_res.ran_process_id   <= r_id[addr];
            r_res.from_round_robin <= rr_unit;
        end
        if (fin) begin
            r_res.finished      <= 1'b1;
            r_res.response_time <= r_resp[addr];
            r_res.finish_time   <= ft;
            r_res.waiting_time  <= wt;
        end
        // all_done is the last field of the result
        if (i_cmd.op == ST_DONE && out_free) begin
            r_out <= {r_res[$bits(t_out_item)-1:1], all_done};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### verif/two_level_feedback_scheduler_chk.sv
// two_level_feedback_scheduler_chk: watches the item, result and register channels of the
// scheduler, predicts every tick result and compares it; depends on tlfs_pkg
module two_level_feedback_scheduler_chk
    import tlfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_item   i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_item  i_out_data,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output int         o_errors,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // scheduler shadow state
    logic [7:0]  quantum, rr_slice;
    logic [4:0]  pcount;
    logic [31:0] tick_now;
    logic [15:0] arr_t [16];
    logic [15:0] bur_t [16];
    logic [15:0] rem_t [16];
    logic [15:0] pid_t [16];
    logic [7:0]  pri_t [16];
    logic [31:0] resp_t [16];
    logic [7:0]  used_t [16];
    logic [3:0]  rrq [16];
    bit          demoted [16];
    bit          started [16];
    logic [3:0]  rr_head;
    logic [4:0]  rr_cnt;
    logic [3:0]  prev_slot;
    bit          prev_valid;

    t_out_item expected_runs[$];
    int        errors;

    assign o_errors  = errors;
    assign o_pending = expected_runs.size();

    function automatic void q_push(logic [3:0] s);
        if (rr_cnt < 16) begin
            rrq[rr_head + rr_cnt[3:0]] = s;
            rr_cnt++;
        end
    endfunction

    function automatic void q_pop();
        if (rr_cnt > 0) begin
            rr_head++;
            rr_cnt--;
        end
    endfunction

    function automatic void q_rotate();
        logic [3:0] f;
        f = rrq[rr_head];
        q_pop();
        q_push(f);
    endfunction

    // fill the run fields and, on completion, the timing fields
    function automatic t_out_item mark_run(t_out_item r, logic [3:0] s, bit rr, logic [31:0] t,
                                           bit fin);
        logic [31:0] ft;
        r.ran_valid        = 1'b1;
        r.ran_slot         = s;
        r.ran_process_id   = pid_t[s];
        r.from_round_robin = rr;
        if (fin) begin
            ft              = (t == 32'hFFFF_FFFF) ? t : t + 1;
            r.finished      = 1'b1;
            r.response_time = resp_t[s];
            r.finish_time   = ft;
            r.waiting_time  = ft - {16'd0, bur_t[s]} - {16'd0, arr_t[s]};
        end
        return r;
    endfunction

    // one scheduling tick
    function automatic t_out_item sched_tick();
        t_out_item   r;
        int          n;
        logic [3:0]  best, f;
        logic [8:0]  bestp;
        logic [15:0] ran;
        logic [31:0] t;
        bit          found, all;
        r     = '0;
        t     = tick_now;
        n     = (pcount < 16) ? pcount : 16;
        bestp = 9'h100;
        best  = '0;
        found = 0;
        for (int i = 0; i < n; i++) begin
            if ({16'd0, arr_t[i]} <= t && {1'b0, pri_t[i]} < bestp && rem_t[i] != 0
                && !demoted[i]) begin
                bestp = {1'b0, pri_t[i]};
                best  = i[3:0];
                found = 1;
            end
        end
        if (!found && rr_cnt > 0) begin
            // round-robin turn
            prev_valid = 0;
            f = rrq[rr_head];
            if (rem_t[f] == 0) begin
                q_pop();
            end else if (used_t[f] >= rr_slice) begin
                used_t[f] = 0;
                q_rotate();
            end else begin
                used_t[f]++;
                rem_t[f]--;
                r = mark_run(r, f, 1'b1, t, rem_t[f] == 0);
                if (rem_t[f] == 0) begin
                    q_pop();
                end else if (used_t[f] == rr_slice) begin
                    used_t[f] = 0;
                    q_rotate();
                end
            end
        end else begin
            // level one takes over, rotate a partly used head
            if (found && rr_cnt > 0 && !prev_valid) begin
                f = rrq[rr_head];
                if (used_t[f] >= 1 && used_t[f] <= rr_slice) q_rotate();
            end
            if (found && !started[best]) begin
                resp_t[best]  = t - {16'd0, arr_t[best]};
                started[best] = 1;
            end
            // preempted process drops to round robin
            if (prev_valid && (!found || best != prev_slot) && !demoted[prev_slot]) begin
                q_push(prev_slot);
                demoted[prev_slot] = 1;
            end
            if (found) begin
                rem_t[best]--;
                ran = bur_t[best] - rem_t[best];
                r   = mark_run(r, best, 1'b0, t, rem_t[best] == 0);
                if (rem_t[best] == 0) begin
                    demoted[best] = 1;
                end else if (ran == {8'd0, quantum}) begin
                    demoted[best] = 1;
                    q_push(best);
                end
            end
            prev_valid = found;
            prev_slot  = best;
        end
        if (tick_now != 32'hFFFF_FFFF) tick_now++;
        all = 1;
        for (int i = 0; i < n; i++) if (rem_t[i] != 0) all = 0;
        r.all_done = all;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
            errors++;
        end
    endtask

    // watch all channels
    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            quantum    = 8'd4;
            rr_slice   = 8'd4;
            pcount     = '0;
            tick_now   = '0;
            rr_head    = '0;
            rr_cnt     = '0;
            prev_slot  = '0;
            prev_valid = 0;
            errors     = 0;
            for (int i = 0; i < 16; i++) begin
                arr_t[i] = '0; bur_t[i] = '0; rem_t[i] = '0; pid_t[i] = '0;
                pri_t[i] = '0; resp_t[i] = '0; used_t[i] = '0; rrq[i] = '0;
                demoted[i] = 0; started[i] = 0;
            end
            expected_runs.delete();
        end else begin
            // register write
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_QUANTUM: quantum  = i_cfg_data;
                    CFG_SLICE:   rr_slice = i_cfg_data;
                    CFG_PCOUNT:  pcount   = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            // result transfer
            if (i_out_valid && i_out_ready) begin
                if (expected_runs.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %h", $time,
                             i_out_data);
                    errors++;
                end else begin
                    e = expected_runs.pop_front();
                    check_field("ran_valid", e.ran_valid, i_out_data.ran_valid);
                    check_field("ran_slot", e.ran_slot, i_out_data.ran_slot);
                    check_field("ran_process_id", e.ran_process_id,
                                i_out_data.ran_process_id);
                    check_field("from_round_robin", e.from_round_robin,
                                i_out_data.from_round_robin);
                    check_field("finished", e.finished, i_out_data.finished);
                    check_field("response_time", e.response_time, i_out_data.response_time);
                    check_field("finish_time", e.finish_time, i_out_data.finish_time);
                    check_field("waiting_time", e.waiting_time, i_out_data.waiting_time);
                    check_field("all_done", e.all_done, i_out_data.all_done);
                end
            end
            // item transfer
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.mode == MODE_LOAD) begin
                    pid_t[i_in_data.slot]   = i_in_data.process_id;
                    arr_t[i_in_data.slot]   = i_in_data.arrival;
                    bur_t[i_in_data.slot]   = i_in_data.burst;
                    rem_t[i_in_data.slot]   = i_in_data.burst;
                    pri_t[i_in_data.slot]   = i_in_data.priority_req;
                    demoted[i_in_data.slot] = 0;
                    started[i_in_data.slot] = 0;
                    used_t[i_in_data.slot]  = '0;
                end else begin
                    expected_runs.push_back(sched_tick());
                end
            end
        end
    end

endmodule

### verif/two_level_feedback_scheduler_tb.sv
// two_level_feedback_scheduler_tb: stimulus, clock, reset and verdict for the scheduler;
// depends on tlfs_pkg, two_level_feedback_scheduler and two_level_feedback_scheduler_chk
module two_level_feedback_scheduler_tb;
    import tlfs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 500000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in_item   in_data;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    int         errors;
    int         pending;
    int         cycles = 0;
    int         ticks_sent;
    bit         idle_en;
    bit         hold_req;
    int         hold_cnt = 0;

    two_level_feedback_scheduler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    two_level_feedback_scheduler_chk chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off
    always @(posedge clk) begin
        if (hold_req && hold_cnt < 400) begin
            hold_cnt  <= hold_cnt + 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= idle_en ? ($urandom_range(99) >= 32) : 1'b1;
        end
    end

    // one item transfer, with random gaps before it
    task automatic offer_item(t_in_item it);
        while (idle_en && $urandom_range(99) < 32) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        if (it.mode == MODE_TICK) ticks_sent++;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // one register transfer; valid is lowered by the caller
    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // wait for every result, then for the block to settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic t_in_item make_tick();
        t_in_item it;
        it      = t_in_item'($bits(t_in_item)'({$urandom, $urandom}));
        it.mode = MODE_TICK;
        return it;
    endfunction

    // random process load, mostly arriving soon with short bursts
    function automatic t_in_item make_load(logic [3:0] s);
        t_in_item it;
        it              = '0;
        it.mode         = MODE_LOAD;
        it.slot         = s;
        it.process_id   = 16'($urandom);
        it.arrival      = ($urandom_range(15) == 0) ? 16'($urandom)
                                                    : 16'(ticks_sent + $urandom_range(10));
        case ($urandom_range(19))
            0:       it.burst = 16'($urandom);
            1:       it.burst = '0;
            default: it.burst = 16'($urandom_range(1, 12));
        endcase
        it.priority_req = ($urandom_range(9) < 7) ? 8'($urandom_range(3))
                                                  : 8'($urandom_range(255));
        return it;
    endfunction

    initial begin
        t_in_item    it;
        logic [7:0]  q, sl;
        logic [4:0]  pc;
        int          nload;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        ticks_sent = 0;
        idle_en   = 1'b1;
        hold_req  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes of the fields, ties, zero burst, late arrival
        write_reg(CFG_QUANTUM, 8'd2);
        write_reg(CFG_SLICE, 8'd1);
        write_reg(CFG_PCOUNT, 8'd16);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 16; i++) begin
            it              = '0;
            it.mode         = MODE_LOAD;
            it.slot         = i[3:0];
            it.process_id   = (i == 1) ? 16'hFFFF : 16'(i);
            it.arrival      = (i == 2) ? 16'd3 : (i == 15) ? 16'hFFFF : 16'd0;
            it.burst        = (i == 3) ? 16'd0 : (i == 5) ? 16'hFFFF : 16'($urandom_range(1, 3));
            it.priority_req = (i == 6) ? 8'd0 : (i == 7) ? 8'hFF : (i < 2) ? 8'd1 : 8'd9;
            offer_item(it);
        end
        repeat (9) offer_item(make_tick());
        drain();

        // random phases through several register settings
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0:       begin q = 8'd1;   sl = 8'd255; pc = 5'd16; end
                1:       begin q = 8'd255; sl = 8'd1;   pc = 5'd0;  end
                2:       begin q = 8'd3;   sl = 8'd2;   pc = 5'd16; end
                default: begin
                    q  = 8'($urandom_range(1, 6));
                    sl = 8'($urandom_range(1, 5));
                    pc = 5'($urandom_range(16));
                end
            endcase
            write_reg(CFG_QUANTUM, q);
            write_reg(CFG_SLICE, sl);
            write_reg(CFG_PCOUNT, {3'd0, pc});
            cfg_valid <= 1'b0;
            idle_en  = (ph != 2);
            if (ph == 3) hold_req = 1'b1;
            nload = ($urandom_range(3) == 0) ? 16 : $urandom_range(1, 6);
            for (int i = 0; i < nload; i++)
                offer_item(make_load((nload == 16) ? i[3:0] : 4'($urandom)));
            for (int i = 0; i < 125; i++) begin
                if ($urandom_range(9) == 0) offer_item(make_load(4'($urandom)));
                else offer_item(make_tick());
            end
            drain();
        end

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
